@@ src/range_sum_segment_tree_core_macros.svh @@
// Assertion macros for the range-sum segment tree core.
`ifndef RANGE_SUM_SEGMENT_TREE_CORE_MACROS_SVH
`define RANGE_SUM_SEGMENT_TREE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define RSST_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsst: same-cycle check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define RSST_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsst: next-cycle check failed");
`else
`define RSST_ASSERT_IMP(label, clk, rst, ante, cons)
`define RSST_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/rsst_pkg.sv @@
// Shared types and constants of the range-sum segment tree core.
package rsst_pkg;

   // Field widths.
   localparam int INDEX_W      = 10;
   localparam int VALUE_W      = 32;
   localparam int SUM_W        = 64;
   localparam int LEAF_COUNT_W = 11;

   // Register port.
   localparam int                  CSR_ADDR_W       = 2;
   localparam int                  CSR_DATA_W       = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_LEAF_COUNT = 2'd0;
   localparam logic [LEAF_COUNT_W-1:0] LEAF_COUNT_RESET = 11'd1024;

   // Operation codes of an input word.
   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_BUILD  = 2'd1,
      MODE_ASSIGN = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                   mode;
      logic [INDEX_W-1:0]         index_lo;
      logic [INDEX_W-1:0]         index_hi;
      logic signed [VALUE_W-1:0]  value;
   } req_word_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] range_sum;
      logic                    range_error;
   } rsp_word_type;

   // Datapath selectors.
   typedef enum logic [1:0] {WA_LPTR, WA_LEAF, WA_HALF} waddr_sel_type;
   typedef enum logic [1:0] {WD_ZERO, WD_VAL, WD_SUM} wdata_sel_type;
   typedef enum logic [2:0] {RA_L2, RA_L2P1, RA_SIB, RA_L, RA_RM1} raddr_sel_type;
   typedef enum logic [2:0] {LP_HOLD, LP_INC, LP_DEC, LP_NM1, LP_LEAF, LP_HALF} lptr_op_type;
   typedef enum logic [1:0] {RP_HOLD, RP_LOAD, RP_HALF} rptr_op_type;
   typedef enum logic [2:0] {AC_HOLD, AC_ZERO, AC_VAL, AC_RD, AC_ADD} acc_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          capture;
      logic          mem_we;
      waddr_sel_type waddr_sel;
      wdata_sel_type wdata_sel;
      logic          mem_re;
      raddr_sel_type raddr_sel;
      lptr_op_type   lptr_op;
      rptr_op_type   rptr_op;
      acc_op_type    acc_op;
      logic          err_load;
      logic          rsp_load;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      mode_type mode;
      logic     index_ok;
      logic     query_ok;
      logic     single_leaf;
      logic     lptr_one;
      logic     l_lt_r;
      logic     l_odd;
      logic     r_odd;
      logic     clear_done;
      logic     rsp_free;
   } dp_status_type;

endpackage

@@ src/rsst_ctrl.sv @@
// Sequencing state machine of the range-sum segment tree core.
module rsst_ctrl
   import rsst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type stat,
   output ctl_cmd_type   cmd
);

   typedef enum logic [10:0] {
      ST_CLEAR    = 11'b000_0000_0001,
      ST_IDLE     = 11'b000_0000_0010,
      ST_DISPATCH = 11'b000_0000_0100,
      ST_B_RD0    = 11'b000_0000_1000,
      ST_B_RD1    = 11'b000_0001_0000,
      ST_B_WR     = 11'b000_0010_0000,
      ST_A_CHK    = 11'b000_0100_0000,
      ST_A_WR     = 11'b000_1000_0000,
      ST_Q_L      = 11'b001_0000_0000,
      ST_Q_R      = 11'b010_0000_0000,
      ST_RESP     = 11'b100_0000_0000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          pend_ff, pend_in;

   // State and pending-read flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in      = state_ff;
      pend_in       = 1'b0;
      req_ready     = 1'b0;
      cmd.capture   = 1'b0;
      cmd.mem_we    = 1'b0;
      cmd.waddr_sel = WA_LPTR;
      cmd.wdata_sel = WD_ZERO;
      cmd.mem_re    = 1'b0;
      cmd.raddr_sel = RA_L;
      cmd.lptr_op   = LP_HOLD;
      cmd.rptr_op   = RP_HOLD;
      cmd.acc_op    = AC_HOLD;
      cmd.err_load  = 1'b0;
      cmd.rsp_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            // Zero one memory entry per cycle after reset.
            cmd.mem_we    = 1'b1;
            cmd.waddr_sel = WA_LPTR;
            cmd.wdata_sel = WD_ZERO;
            cmd.lptr_op   = LP_INC;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_IDLE;
            case (stat.mode)
               MODE_LOAD: begin
                  if (stat.index_ok) begin
                     cmd.mem_we    = 1'b1;
                     cmd.waddr_sel = WA_LEAF;
                     cmd.wdata_sel = WD_VAL;
                  end
               end
               MODE_BUILD: begin
                  cmd.lptr_op = LP_NM1;
                  if (!stat.single_leaf) begin
                     state_in = ST_B_RD0;
                  end
               end
               MODE_ASSIGN: begin
                  if (stat.index_ok) begin
                     cmd.mem_we    = 1'b1;
                     cmd.waddr_sel = WA_LEAF;
                     cmd.wdata_sel = WD_VAL;
                     cmd.lptr_op   = LP_LEAF;
                     cmd.acc_op    = AC_VAL;
                     state_in      = ST_A_CHK;
                  end
               end
               MODE_QUERY: begin
                  cmd.acc_op   = AC_ZERO;
                  cmd.err_load = 1'b1;
                  if (stat.query_ok) begin
                     cmd.lptr_op = LP_LEAF;
                     cmd.rptr_op = RP_LOAD;
                     state_in    = ST_Q_L;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         // Build: read both children, then write their sum to the parent.
         ST_B_RD0: begin
            cmd.mem_re    = 1'b1;
            cmd.raddr_sel = RA_L2;
            state_in      = ST_B_RD1;
         end
         ST_B_RD1: begin
            cmd.mem_re    = 1'b1;
            cmd.raddr_sel = RA_L2P1;
            cmd.acc_op    = AC_RD;
            state_in      = ST_B_WR;
         end
         ST_B_WR: begin
            cmd.mem_we    = 1'b1;
            cmd.waddr_sel = WA_LPTR;
            cmd.wdata_sel = WD_SUM;
            cmd.lptr_op   = LP_DEC;
            state_in      = stat.lptr_one ? ST_IDLE : ST_B_RD0;
         end
         // Assign: walk to the root, reading each sibling once.
         ST_A_CHK: begin
            if (stat.lptr_one) begin
               state_in = ST_IDLE;
            end else begin
               cmd.mem_re    = 1'b1;
               cmd.raddr_sel = RA_SIB;
               state_in      = ST_A_WR;
            end
         end
         ST_A_WR: begin
            cmd.mem_we    = 1'b1;
            cmd.waddr_sel = WA_HALF;
            cmd.wdata_sel = WD_SUM;
            cmd.acc_op    = AC_ADD;
            cmd.lptr_op   = LP_HALF;
            state_in      = ST_A_CHK;
         end
         // Query, left edge: add any pending term, read the left node if odd.
         ST_Q_L: begin
            if (pend_ff) begin
               cmd.acc_op = AC_ADD;
            end
            if (!stat.l_lt_r) begin
               state_in = ST_RESP;
            end else begin
               if (stat.l_odd) begin
                  cmd.mem_re    = 1'b1;
                  cmd.raddr_sel = RA_L;
                  cmd.lptr_op   = LP_INC;
                  pend_in       = 1'b1;
               end
               state_in = ST_Q_R;
            end
         end
         // Query, right edge: add any pending term, read the right node if
         // odd, and move both edges up one level.
         ST_Q_R: begin
            if (pend_ff) begin
               cmd.acc_op = AC_ADD;
            end
            if (stat.r_odd) begin
               cmd.mem_re    = 1'b1;
               cmd.raddr_sel = RA_RM1;
               pend_in       = 1'b1;
            end
            cmd.lptr_op = LP_HALF;
            cmd.rptr_op = RP_HALF;
            state_in    = ST_Q_L;
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

@@ src/rsst_datapath.sv @@
// Tree memory, pointers, accumulator and result register of the segment tree.
module rsst_datapath
   import rsst_pkg::*;
#(
   parameter int LEAVES = 1024
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [LEAF_COUNT_W-1:0] leaf_count,
   input  req_word_type            req_word,
   input  ctl_cmd_type             cmd,
   output dp_status_type           stat,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_word_type            rsp_word
);

   localparam int DEPTH = 2 * LEAVES;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = AW + 1;
   localparam int CW    = (PW > LEAF_COUNT_W) ? PW : LEAF_COUNT_W;

   logic [SUM_W-1:0] mem [DEPTH];

   req_word_type     item_ff;
   logic [PW-1:0]    lptr_ff, lptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0] rdata_ff;
   logic             err_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff;

   logic [CW-1:0]    lc_c, n_c, lo_c, hi_c, leaf_c, qend_c, nm1_c;
   logic [AW-1:0]    waddr, raddr;
   logic [SUM_W-1:0] wdata, sum_w, val_ext;

   // Leaf count in use, clamped to one through LEAVES.
   always_comb begin
      lc_c = CW'(leaf_count);
      if (lc_c == '0) begin
         n_c = CW'(1);
      end else if (lc_c > CW'(LEAVES)) begin
         n_c = CW'(LEAVES);
      end else begin
         n_c = lc_c;
      end
   end

   assign lo_c    = CW'(item_ff.index_lo);
   assign hi_c    = CW'(item_ff.index_hi);
   assign leaf_c  = n_c + lo_c;
   assign qend_c  = n_c + hi_c + CW'(1);
   assign nm1_c   = n_c - CW'(1);
   assign val_ext = {{(SUM_W - VALUE_W){item_ff.value[VALUE_W-1]}}, item_ff.value};
   assign sum_w   = acc_ff + rdata_ff;

   // Status toward the controller.
   always_comb begin
      stat.mode        = item_ff.mode;
      stat.index_ok    = lo_c < n_c;
      stat.query_ok    = (lo_c < n_c) && (hi_c < n_c) && (lo_c <= hi_c);
      stat.single_leaf = n_c == CW'(1);
      stat.lptr_one    = lptr_ff == PW'(1);
      stat.l_lt_r      = lptr_ff < rptr_ff;
      stat.l_odd       = lptr_ff[0];
      stat.r_odd       = rptr_ff[0];
      stat.clear_done  = lptr_ff == PW'(DEPTH - 1);
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // Memory address and data selection.
   always_comb begin
      case (cmd.waddr_sel)
         WA_LPTR: waddr = lptr_ff[AW-1:0];
         WA_LEAF: waddr = leaf_c[AW-1:0];
         WA_HALF: waddr = lptr_ff[AW:1];
         default: waddr = lptr_ff[AW-1:0];
      endcase
      case (cmd.wdata_sel)
         WD_ZERO: wdata = '0;
         WD_VAL:  wdata = val_ext;
         WD_SUM:  wdata = sum_w;
         default: wdata = '0;
      endcase
      case (cmd.raddr_sel)
         RA_L2:   raddr = {lptr_ff[AW-2:0], 1'b0};
         RA_L2P1: raddr = {lptr_ff[AW-2:0], 1'b1};
         RA_SIB:  raddr = lptr_ff[AW-1:0] ^ AW'(1);
         RA_L:    raddr = lptr_ff[AW-1:0];
         RA_RM1:  raddr = {rptr_ff[AW-1:1], 1'b0};
         default: raddr = lptr_ff[AW-1:0];
      endcase
   end

   // Tree memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.mem_re) begin
         rdata_ff <= mem[raddr];
      end
   end

   // Pointer and accumulator updates.
   always_comb begin
      case (cmd.lptr_op)
         LP_HOLD: lptr_in = lptr_ff;
         LP_INC:  lptr_in = lptr_ff + PW'(1);
         LP_DEC:  lptr_in = lptr_ff - PW'(1);
         LP_NM1:  lptr_in = nm1_c[PW-1:0];
         LP_LEAF: lptr_in = leaf_c[PW-1:0];
         LP_HALF: lptr_in = lptr_ff >> 1;
         default: lptr_in = lptr_ff;
      endcase
      case (cmd.rptr_op)
         RP_HOLD: rptr_in = rptr_ff;
         RP_LOAD: rptr_in = qend_c[PW-1:0];
         RP_HALF: rptr_in = rptr_ff >> 1;
         default: rptr_in = rptr_ff;
      endcase
      case (cmd.acc_op)
         AC_HOLD: acc_in = acc_ff;
         AC_ZERO: acc_in = '0;
         AC_VAL:  acc_in = val_ext;
         AC_RD:   acc_in = rdata_ff;
         AC_ADD:  acc_in = sum_w;
         default: acc_in = acc_ff;
      endcase
   end

   // The left pointer also sweeps the clearing pass, so it resets.
   always_ff @(posedge clock) begin
      if (reset) begin
         lptr_ff <= '0;
      end else begin
         lptr_ff <= lptr_in;
      end
   end

   always_ff @(posedge clock) begin
      rptr_ff <= rptr_in;
      acc_ff  <= acc_in;
      if (cmd.capture) begin
         item_ff <= req_word;
      end
      if (cmd.err_load) begin
         err_ff <= !stat.query_ok;
      end
   end

   // Result register: holds a word until the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_word_ff.range_sum   <= acc_ff;
         rsp_word_ff.range_error <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ src/range_sum_segment_tree_core.sv @@
// Top level of the range-sum segment tree core: register port and assertions.
//
//   Channel   Direction   Word / data                 Handshake
//   req_      in          req_word_type               req_valid / req_ready
//   rsp_      out         rsp_word_type               rsp_valid / rsp_ready
//   csr_      in/out      11-bit leaf_count at 0x0    APB setup + access
//
// After reset a clearing pass zeroes the tree memory with req_ready low. A
// load writes its leaf from the dispatch state; a build visits each internal
// node, and an assign and a query each tree level, through the single memory
// read port. One word is in work at a time; a finished query result waits
// in the output register while the next word is taken, and a further query
// stalls only at its end if that result is unread.
`include "range_sum_segment_tree_core_macros.svh"

module range_sum_segment_tree_core
   import rsst_pkg::*;
#(
   parameter int LEAVES = 1024
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LEAF_COUNT_W-1:0] leaf_count_ff, leaf_count_in;
   logic                    csr_write;
   ctl_cmd_type             ctl_cmd;
   dp_status_type           dp_stat;
   logic                    rsp_err_out;

   // Register port: writes land in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      leaf_count_in = leaf_count_ff;
      if (csr_write && (csr_paddr == ADDR_LEAF_COUNT)) begin
         leaf_count_in = csr_pwdata[LEAF_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= LEAF_COUNT_RESET;
      end else begin
         leaf_count_ff <= leaf_count_in;
      end
   end

   assign csr_prdata = (csr_paddr == ADDR_LEAF_COUNT) ?
                       CSR_DATA_W'(leaf_count_ff) : '0;

   // Controller and datapath.
   rsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (ctl_cmd)
   );

   rsst_datapath #(
      .LEAVES (LEAVES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .leaf_count (leaf_count_ff),
      .req_word   (req_word),
      .cmd        (ctl_cmd),
      .stat       (dp_stat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

   // A rejected query word is on the output.
   assign rsp_err_out = rsp_valid && rsp_word.range_error;

   // A word is never loaded over one that has not been taken.
   `RSST_ASSERT_IMP(a_rsp_no_overwrite, clock, reset, ctl_cmd.rsp_load, !rsp_valid || rsp_ready)
   // The memory never reads and writes in the same cycle.
   `RSST_ASSERT_IMP(a_mem_one_access, clock, reset, ctl_cmd.mem_we, !ctl_cmd.mem_re)
   // One word in work at a time: input closes right after an accept.
   `RSST_ASSERT_NXT(a_req_single, clock, reset, req_valid && req_ready, !req_ready)
   // A rejected query reports a zero sum.
   `RSST_ASSERT_IMP(a_err_zero_sum, clock, reset, rsp_err_out, rsp_word.range_sum == '0)

endmodule
